/* design/cait_pkg.sv */
// cait_pkg: shared types, constants and helpers for the call argument index tracker
// no dependencies; used by the interfaces, cait_scan and call_argument_index_tracker

package cait_pkg;

  // saturation limits of the scan counters
  localparam int MAX_NEST = 255;
  localparam int MAX_ARGS = 255;

  // counter widths follow from the limits
  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int ARGS_W = $clog2(MAX_ARGS + 1);

  // widths of the request and result fields
  localparam int CH_W  = 8;
  localparam int IDX_W = 8;

  // character codes the scanner reacts to
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

  // scan state carried from one character to the next
  typedef struct packed {
    logic              in_quote;
    logic              quote_is_single;
    logic              skip_escaped;
    logic [NEST_W-1:0] nest_level;
    logic [ARGS_W-1:0] comma_total;
    logic              closed_flag;
  } scan_state_t;

  // reported argument index: zero once closed, clipped to the field width
  function automatic logic [IDX_W-1:0] index_of(scan_state_t s);
    logic [31:0] wide;
    wide = 32'(s.comma_total);
    if (s.closed_flag) begin
      return '0;
    end
    if (wide > 32'((1 << IDX_W) - 1)) begin
      return {IDX_W{1'b1}};
    end
    return wide[IDX_W-1:0];
  endfunction

endpackage

/* design/cait_if.sv */
// cait_req_if and cait_res_if: valid/ready channels for characters and results
// depends on cait_pkg for field widths

interface cait_req_if;
  import cait_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            first;
  logic            last;

  modport source (output valid, output ch, output first, output last, input ready);
  modport sink   (input valid, input ch, input first, input last, output ready);
endinterface

interface cait_res_if;
  import cait_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] arg_index;
  logic             call_closed;
  logic             end_of_scan;

  modport source (output valid, output arg_index, output call_closed, output end_of_scan,
                  input ready);
  modport sink   (input valid, input arg_index, input call_closed, input end_of_scan,
                  output ready);
endinterface

/* design/cait_scan.sv */
// cait_scan: next scan state for one character (quotes, escapes, nesting, commas)
// depends on cait_pkg

module cait_scan (
  input  cait_pkg::scan_state_t     cur,
  input  logic [cait_pkg::CH_W-1:0] ch,
  input  logic                      first,
  output cait_pkg::scan_state_t     nxt
);
  import cait_pkg::*;

  scan_state_t base;

  always_comb begin
    // a first mark restarts the scan before this character
    base = first ? '0 : cur;
    nxt  = base;
    if (!base.closed_flag) begin
      if (base.in_quote) begin
        // inside a string: escapes and the matching quote only
        if (base.skip_escaped) begin
          nxt.skip_escaped = 1'b0;
        end else if (ch == CH_BSLASH) begin
          nxt.skip_escaped = 1'b1;
        end else if (ch == (base.quote_is_single ? CH_SQUOTE : CH_DQUOTE)) begin
          nxt.in_quote = 1'b0;
        end
      end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
        // opening quote
        nxt.in_quote        = 1'b1;
        nxt.quote_is_single = (ch == CH_SQUOTE);
        nxt.skip_escaped    = 1'b0;
      end else if (ch == CH_LPAREN) begin
        // nesting, saturating
        if (base.nest_level < NEST_W'(MAX_NEST)) begin
          nxt.nest_level = base.nest_level + NEST_W'(1);
        end
      end else if (ch == CH_RPAREN) begin
        // unmatched close ends the call
        if (base.nest_level == '0) begin
          nxt.closed_flag = 1'b1;
        end else begin
          nxt.nest_level = base.nest_level - NEST_W'(1);
        end
      end else if (ch == CH_COMMA && base.nest_level == '0) begin
        // top-level comma, saturating
        if (base.comma_total < ARGS_W'(MAX_ARGS)) begin
          nxt.comma_total = base.comma_total + ARGS_W'(1);
        end
      end
    end
  end

endmodule

/* design/call_argument_index_tracker.sv */
// call_argument_index_tracker: top level, input register, scan state and result register
// depends on cait_pkg, cait_if.sv (cait_req_if, cait_res_if) and cait_scan
//
//  channel  dir  payload                              request moves
//  chars    in   ch[7:0], first, last                 one line character
//  result   out  arg_index[7:0], call_closed, end_of_scan  one answer per character
//
// One character per cycle while results are accepted; each answer is presented once its
// character has passed the input register, then the scan logic into the result register.
// The scan state update is a registered loop of compares and one counter step.
// rst (synchronous) clears the scan state and both stage valids.
// A stalled result holds; the input register still takes a character while it is
// empty, or while the result register is free or being drained in the same cycle.

module call_argument_index_tracker (
  input  logic       clk,
  input  logic       rst,
  cait_req_if.sink   chars,
  cait_res_if.source result
);
  import cait_pkg::*;

  // input register
  logic            s1_v;
  logic [CH_W-1:0] s1_ch;
  logic            s1_first;
  logic            s1_last;

  // scan state and result register
  scan_state_t      state;
  scan_state_t      state_next;
  logic             res_v;
  logic [IDX_W-1:0] res_index;
  logic             res_closed;
  logic             res_end;

  logic adv;
  logic take;

  // stage handshakes
  assign adv         = s1_v && (!res_v || result.ready);
  assign chars.ready = !s1_v || adv;
  assign take        = chars.valid && chars.ready;

  cait_scan u_scan (
    .cur   (state),
    .ch    (s1_ch),
    .first (s1_first),
    .nxt   (state_next)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (take) begin
      s1_v <= 1'b1;
    end else if (adv) begin
      s1_v <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_ch    <= chars.ch;
      s1_first <= chars.first;
      s1_last  <= chars.last;
    end
  end

  // scan state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      res_v <= 1'b0;
    end else begin
      if (adv) begin
        state <= state_next;
      end
      if (adv) begin
        res_v <= 1'b1;
      end else if (result.ready) begin
        res_v <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      res_index  <= index_of(state_next);
      res_closed <= state_next.closed_flag;
      res_end    <= s1_last;
    end
  end

  assign result.valid       = res_v;
  assign result.arg_index   = res_index;
  assign result.call_closed = res_closed;
  assign result.end_of_scan = res_end;

  // closed holds until a first mark restarts the scan
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    state.closed_flag && !(adv && s1_first) |=> state.closed_flag)
    else $error("closed flag dropped without a restart");

  // nesting never passes its limit
  a_nest_limit: assert property (@(posedge clk) disable iff (rst)
    state.nest_level <= NEST_W'(MAX_NEST))
    else $error("nest level beyond limit");

  // inside a string, counters stay put
  a_quote_quiet: assert property (@(posedge clk) disable iff (rst)
    adv && state.in_quote && !s1_first
      |=> $stable(state.comma_total) && $stable(state.nest_level))
    else $error("counter moved inside a string");

  // every character moved out of the input register yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    adv |=> res_v)
    else $error("result missing after advance");

endmodule
